### hdl/task_priority_sorter_defines.svh
// ----------------------------------------------------------------------------
// task_priority_sorter_defines: assertion macros
// Shared concurrent assertion wrappers for the sorter checker.
// ----------------------------------------------------------------------------
`ifndef TASK_PRIORITY_SORTER_DEFINES_SVH
`define TASK_PRIORITY_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TPS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sorter check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted
`define TPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sorter check failed (next cycle)");

`endif

### hdl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: task priority sorter package
// Record type, cell control bundle, state encoding and the sort order.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned IdW   = 15;
  localparam int unsigned PrioW = 8;
  localparam int unsigned TimeW = 20;

  // One stored task record
  typedef struct packed {
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] task_priority;
    logic [TimeW-1:0] run_time;
  } rec_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic insert;  // place the incoming record into the chain
    logic shift;   // move every record one cell toward the head
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  // True when record a must come out before record b
  function automatic logic goes_before(rec_t a, rec_t b);
    logic res;
    if (a.task_priority != b.task_priority) begin
      res = (a.task_priority > b.task_priority);
    end else if (a.run_time != b.run_time) begin
      res = (a.run_time < b.run_time);
    end else begin
      res = (a.task_id < b.task_id);
    end
    return res;
  endfunction

endpackage

### hdl/tps_if.sv
// ----------------------------------------------------------------------------
// tps_if: sorter channel interfaces
// Valid/ready channels for incoming task words and sorted result words.
// ----------------------------------------------------------------------------
interface tps_task_if;
  logic                           valid;
  logic                           ready;
  logic [tps_pkg::IdW-1:0]        task_id;
  logic [tps_pkg::PrioW-1:0]      task_priority;
  logic [tps_pkg::TimeW-1:0]      run_time;
  logic                           batch_end;

  modport source (output valid, task_id, task_priority, run_time, batch_end,
                  input ready);
  modport sink   (input valid, task_id, task_priority, run_time, batch_end,
                  output ready);
endinterface

interface tps_result_if;
  logic                           valid;
  logic                           ready;
  logic [tps_pkg::IdW-1:0]        out_id;
  logic [tps_pkg::PrioW-1:0]      out_priority;
  logic [tps_pkg::TimeW-1:0]      out_time;
  logic                           run_last;
  logic                           overflowed;

  modport source (output valid, out_id, out_priority, out_time, run_last, overflowed,
                  input ready);
  modport sink   (input valid, out_id, out_priority, out_time, run_last, overflowed,
                  output ready);
endinterface

### hdl/task_priority_sorter.sv
// ----------------------------------------------------------------------------
// task_priority_sorter: multi-key priority sort of a batch of task records
//
//   channel   dir  handshake     word contents
//   task_i    in   valid/ready   task_id, task_priority, run_time, batch_end
//   result_o  out  valid/ready   out_id, out_priority, out_time, run_last,
//                                overflowed
//
// Load: one task word per cycle; the insertion chain of MAX_TASKS cells
// places it as it is taken, or drops it when full. The batch_end word
// switches to emit. Emit: one result word per cycle from the head cell;
// task_i.ready stays low until the run_last word is taken.
// Reset clears all cell valid bits, the drop flag and the state; no clear pass.
// A stall on result_o holds the head word and the whole chain.
// ----------------------------------------------------------------------------
module task_priority_sorter #(
  parameter int unsigned MAX_TASKS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tps_task_if.sink     task_i,
  tps_result_if.source result_o
);

  tps_pkg::state_e     state_q, state_d;
  tps_pkg::cell_ctrl_t ctrl;
  tps_pkg::rec_t       new_rec;
  tps_pkg::rec_t       rec_w   [MAX_TASKS];
  logic                valid_w [MAX_TASKS];
  logic                place_w [MAX_TASKS];
  logic                drop_q, drop_d;
  logic                in_acc, out_acc, full, last_word;

  assign in_acc    = task_i.valid && task_i.ready;
  assign out_acc   = result_o.valid && result_o.ready;
  assign full      = valid_w[MAX_TASKS-1];
  assign last_word = !valid_w[1];

  assign new_rec.task_id       = task_i.task_id;
  assign new_rec.task_priority = task_i.task_priority;
  assign new_rec.run_time      = task_i.run_time;

  // Insert only while there is room; drain on each taken result word
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  // Build the cell chain
  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    tps_pkg::rec_t left_rec, right_rec;
    logic          left_valid, left_place, right_valid;

    if (k == 0) begin : g_head
      assign left_rec   = '0;
      assign left_valid = 1'b0;
      assign left_place = 1'b0;
    end else begin : g_mid
      assign left_rec   = rec_w[k-1];
      assign left_valid = valid_w[k-1];
      assign left_place = place_w[k-1];
    end

    if (k == MAX_TASKS - 1) begin : g_tail
      assign right_rec   = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_rec   = rec_w[k+1];
      assign right_valid = valid_w[k+1];
    end

    tps_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_rec_i     (new_rec),
      .left_rec_i    (left_rec),
      .left_valid_i  (left_valid),
      .left_place_i  (left_place),
      .right_rec_i   (right_rec),
      .right_valid_i (right_valid),
      .place_o       (place_w[k]),
      .rec_o         (rec_w[k]),
      .valid_o       (valid_w[k])
    );
  end

  // Set drop flag on a discarded word, clear it after the run
  always_comb begin
    drop_d = drop_q;
    if (in_acc && full) begin
      drop_d = 1'b1;
    end else if (out_acc && last_word) begin
      drop_d = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tps_pkg::ST_LOAD: begin
        if (in_acc && task_i.batch_end) begin
          state_d = tps_pkg::ST_EMIT;
        end
      end
      tps_pkg::ST_EMIT: begin
        if (out_acc && last_word) begin
          state_d = tps_pkg::ST_LOAD;
        end
      end
      default: state_d = tps_pkg::ST_LOAD;
    endcase
  end

  // Handshake outputs
  always_comb begin
    task_i.ready   = 1'b0;
    result_o.valid = 1'b0;
    case (state_q)
      tps_pkg::ST_LOAD: task_i.ready   = 1'b1;
      tps_pkg::ST_EMIT: result_o.valid = 1'b1;
      default: begin
        task_i.ready   = 1'b0;
        result_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tps_pkg::ST_LOAD;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  // Head cell drives the result word
  assign result_o.out_id       = rec_w[0].task_id;
  assign result_o.out_priority = rec_w[0].task_priority;
  assign result_o.out_time     = rec_w[0].run_time;
  assign result_o.run_last     = last_word;
  assign result_o.overflowed   = drop_q;

endmodule

### hdl/tps_cell.sv
// ----------------------------------------------------------------------------
// tps_cell: one slot of the insertion chain
// Holds one record; compares it with the incoming record, takes the new
// record or the left neighbor's on insert, the right neighbor's on emit.
// ----------------------------------------------------------------------------
module tps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tps_pkg::cell_ctrl_t ctrl_i,
  input  tps_pkg::rec_t       new_rec_i,
  input  tps_pkg::rec_t       left_rec_i,
  input  logic                left_valid_i,
  input  logic                left_place_i,
  input  tps_pkg::rec_t       right_rec_i,
  input  logic                right_valid_i,
  output logic                place_o,
  output tps_pkg::rec_t       rec_o,
  output logic                valid_o
);

  tps_pkg::rec_t rec_q, rec_d;
  logic          valid_q, valid_d;

  // New record belongs here or earlier when this slot is empty or ranks lower
  assign place_o = !valid_q || tps_pkg::goes_before(new_rec_i, rec_q);

  // Select next contents: shift toward head, shift away on insert, or load
  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      rec_d   = right_rec_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert && place_o) begin
      if (left_place_i) begin
        rec_d   = left_rec_i;
        valid_d = left_valid_i;
      end else begin
        rec_d   = new_rec_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

### hdl/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker: port-level checks for the task priority sorter
// Watches both channels and checks load/emit sequencing over time.
// ----------------------------------------------------------------------------
`include "task_priority_sorter_defines.svh"

module tps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_batch_end_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tps_pkg::IdW-1:0]     out_id_i,
  input logic                        out_run_last_i,
  input logic                        out_overflowed_i
);

  // Never load and emit in the same cycle
  `TPS_ASSERT_SAME(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i)

  // A batch_end word starts the run on the next cycle
  `TPS_ASSERT_NEXT(a_run_starts, clk_i, rst_ni,
                   in_valid_i && in_ready_i && in_batch_end_i, out_valid_i)

  // Taking the last word returns to load
  `TPS_ASSERT_NEXT(a_run_ends, clk_i, rst_ni,
                   out_valid_i && out_ready_i && out_run_last_i,
                   in_ready_i && !out_valid_i)

  // Overflow flag holds for the whole run
  `TPS_ASSERT_NEXT(a_flag_steady, clk_i, rst_ni,
                   out_valid_i && out_ready_i && !out_run_last_i,
                   out_valid_i && (out_overflowed_i == $past(out_overflowed_i)))

  // Stalled result word holds
  `TPS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_id_i) && $stable(out_run_last_i))

endmodule

bind task_priority_sorter tps_checker u_tps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (task_i.valid),
  .in_ready_i       (task_i.ready),
  .in_batch_end_i   (task_i.batch_end),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .out_id_i         (result_o.out_id),
  .out_run_last_i   (result_o.run_last),
  .out_overflowed_i (result_o.overflowed)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for task_priority_sorter
// Feeds batches of task words and predicts each sorted run: priority high to
// low, then run time low to high, then id low to high, with overflow flagged.
// Both channels stall at random. The sink holds off for a long stretch once,
// and the source waits for a drained block before some batches.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_TASKS    = 32;
  localparam int unsigned RANDOM_TASKS = 380;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_CAP   = 50;

  // Gap styles for one batch on the task side
  typedef enum int {
    GAP_NONE,
    GAP_RANDOM,
    GAP_SPARSE
  } gap_style_e;

  // One pending task word with its send timing
  typedef struct {
    tps_pkg::rec_t rec;
    logic          batch_end;
    int unsigned   gap;
    bit            after_drain;
    bit            hold_sink;
  } task_item_t;

  // One expected result word
  typedef struct packed {
    tps_pkg::rec_t rec;
    logic          run_last;
    logic          overflowed;
  } sorted_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b1;

  tps_task_if   task_if ();
  tps_result_if result_if ();

  task_priority_sorter #(
    .MAX_TASKS(MAX_TASKS)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .task_i  (task_if),
    .result_o(result_if)
  );

  task_item_t    pending[$];
  task_item_t    cur_task;
  tps_pkg::rec_t sort_store[$];
  bit            batch_dropped;
  sorted_word_t  sorted_words[$];

  int unsigned total_tasks;
  int unsigned tasks_taken;
  int unsigned words_due;
  int unsigned words_seen;
  int unsigned hold_asks;
  int unsigned hold_served;
  int unsigned idle_cycles;
  int unsigned due_add;
  int unsigned sink_wait;
  int unsigned long_wait;
  int unsigned words_checked;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  bit          drv_taken;
  bit          sink_burst;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Sort key: priority descending, run time ascending, id ascending
  function automatic bit ranks_ahead(tps_pkg::rec_t a, tps_pkg::rec_t b);
    return {a.task_priority, ~a.run_time, ~a.task_id} >
           {b.task_priority, ~b.run_time, ~b.task_id};
  endfunction

  // Place one accepted task; on batch end queue the sorted run, return its size
  function automatic int unsigned place_task(task_item_t it);
    int unsigned  pos;
    int unsigned  run_len;
    bit           found;
    sorted_word_t w;
    if (sort_store.size() >= MAX_TASKS) begin
      batch_dropped = 1'b1;
    end else begin
      pos   = sort_store.size();
      found = 1'b0;
      foreach (sort_store[k]) begin
        if (!found && ranks_ahead(it.rec, sort_store[k])) begin
          pos   = k;
          found = 1'b1;
        end
      end
      sort_store.insert(pos, it.rec);
    end
    run_len = 0;
    if (it.batch_end) begin
      run_len = sort_store.size();
      foreach (sort_store[k]) begin
        w.rec        = sort_store[k];
        w.run_last   = (k == int'(run_len) - 1);
        w.overflowed = batch_dropped;
        sorted_words.push_back(w);
      end
      sort_store.delete();
      batch_dropped = 1'b0;
    end
    return run_len;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Compare the word on the result channel with the oldest expectation
  task automatic check_result_word();
    sorted_word_t want;
    if (sorted_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word id=%0d", result_if.out_id));
      return;
    end
    want = sorted_words.pop_front();
    if (result_if.out_id !== want.rec.task_id)
      report_mismatch($sformatf("out_id got %0d want %0d",
                                result_if.out_id, want.rec.task_id));
    if (result_if.out_priority !== want.rec.task_priority)
      report_mismatch($sformatf("out_priority got %0d want %0d (id %0d)",
                                result_if.out_priority, want.rec.task_priority,
                                want.rec.task_id));
    if (result_if.out_time !== want.rec.run_time)
      report_mismatch($sformatf("out_time got %0d want %0d (id %0d)",
                                result_if.out_time, want.rec.run_time,
                                want.rec.task_id));
    if (result_if.run_last !== want.run_last)
      report_mismatch($sformatf("run_last got %b want %b (id %0d)",
                                result_if.run_last, want.run_last, want.rec.task_id));
    if (result_if.overflowed !== want.overflowed)
      report_mismatch($sformatf("overflowed got %b want %b (id %0d)",
                                result_if.overflowed, want.overflowed,
                                want.rec.task_id));
  endtask

  // ------------------------------------------------------------------------
  // Stimulus construction
  // ------------------------------------------------------------------------

  task automatic push_task(int unsigned id, int unsigned prio, int unsigned rtime,
                           bit last, int unsigned gap, bit after_drain, bit hold_sink);
    task_item_t it;
    logic [31:0] raw_id;
    logic [31:0] raw_prio;
    logic [31:0] raw_time;
    raw_id         = id;
    raw_prio       = prio;
    raw_time       = rtime;
    it.rec.task_id       = raw_id[tps_pkg::IdW-1:0];
    it.rec.task_priority = raw_prio[tps_pkg::PrioW-1:0];
    it.rec.run_time      = raw_time[tps_pkg::TimeW-1:0];
    it.batch_end   = last;
    it.gap         = gap;
    it.after_drain = after_drain;
    it.hold_sink   = hold_sink;
    pending.push_back(it);
  endtask

  // Draw one field set: full range or a narrow set that forces key ties
  task automatic draw_fields(output int unsigned id, output int unsigned prio,
                             output int unsigned rtime);
    if ($urandom_range(0, 1) == 0) id = $urandom_range(0, 32767);
    else id = $urandom_range(0, 6);
    if ($urandom_range(0, 1) == 0) prio = $urandom_range(0, 255);
    else prio = $urandom_range(0, 3);
    if ($urandom_range(0, 1) == 0) begin
      rtime = $urandom_range(0, 1048575);
    end else begin
      case ($urandom_range(0, 4))
        0: rtime = 0;
        1: rtime = 1;
        2: rtime = 100000;
        3: rtime = 1000000;
        default: rtime = 1048575;
      endcase
    end
  endtask

  function automatic int unsigned draw_gap(gap_style_e style);
    int unsigned g;
    case (style)
      GAP_NONE:   g = 0;
      GAP_RANDOM: g = $urandom_range(0, 15);
      default:    g = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
    return g;
  endfunction

  task automatic add_batch(int unsigned size, gap_style_e style, bit after_drain,
                           bit hold_sink);
    int unsigned id;
    int unsigned prio;
    int unsigned rtime;
    for (int unsigned n = 0; n < size; n++) begin
      draw_fields(id, prio, rtime);
      push_task(id, prio, rtime, n == size - 1, draw_gap(style),
                after_drain && n == 0, hold_sink && n == size - 1);
    end
  endtask

  task automatic build_stimulus();
    int unsigned sel;
    int unsigned size;
    int unsigned random_count;
    gap_style_e  style;
    // Single record, priority and run time at the low extremes
    push_task(1, 0, 0, 1'b1, 0, 1'b0, 1'b0);
    // Full keys equal except id; id zero sorts first
    push_task(32767, 255, 1048575, 1'b0, 0, 1'b0, 1'b0);
    push_task(0, 255, 1048575, 1'b1, 3, 1'b0, 1'b0);
    // Identical records: same id, priority and run time
    push_task(5, 7, 9, 1'b0, 0, 1'b0, 1'b0);
    push_task(5, 7, 9, 1'b0, 1, 1'b0, 1'b0);
    push_task(5, 7, 9, 1'b1, 0, 1'b0, 1'b0);
    // Priority first, then run time, then id
    push_task(10, 100, 1000000, 1'b0, 0, 1'b1, 1'b0);
    push_task(11, 100, 100000, 1'b0, 2, 1'b0, 1'b0);
    push_task(12, 101, 1048575, 1'b0, 0, 1'b0, 1'b0);
    push_task(13, 99, 0, 1'b0, 0, 1'b0, 1'b0);
    push_task(9, 100, 100000, 1'b1, 0, 1'b0, 1'b0);
    // Overflowing burst with a long sink hold-off, next batch offered at once
    add_batch(MAX_TASKS + 8, GAP_NONE, 1'b1, 1'b1);
    add_batch(6, GAP_NONE, 1'b0, 1'b0);
    // Full store with the batch end record dropped, after a drain
    add_batch(MAX_TASKS + 1, GAP_SPARSE, 1'b1, 1'b0);
    // Exactly full store, no drop
    add_batch(MAX_TASKS, GAP_RANDOM, 1'b0, 1'b0);

    random_count = 0;
    while (random_count < RANDOM_TASKS) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) size = $urandom_range(1, 10);
      else if (sel < 82) size = $urandom_range(11, MAX_TASKS - 1);
      else if (sel < 92) size = MAX_TASKS;
      else size = $urandom_range(MAX_TASKS + 1, MAX_TASKS + 8);
      case ($urandom_range(0, 2))
        0: style = GAP_NONE;
        1: style = GAP_RANDOM;
        default: style = GAP_SPARSE;
      endcase
      add_batch(size, style, $urandom_range(0, 9) == 0, 1'b0);
      random_count += size;
    end
  endtask

  // ------------------------------------------------------------------------
  // Task driver: offer the next pending word once its gap has passed
  // ------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      task_if.valid         <= 1'b0;
      task_if.task_id       <= '0;
      task_if.task_priority <= '0;
      task_if.run_time      <= '0;
      task_if.batch_end     <= 1'b0;
      tasks_taken           <= 0;
      words_due             <= 0;
      hold_asks             <= 0;
      idle_cycles = 0;
    end else begin
      drv_taken = task_if.valid && task_if.ready;
      // Predict the accepted word
      if (drv_taken) begin
        due_add = place_task(cur_task);
        tasks_taken <= tasks_taken + 1;
        words_due   <= words_due + due_add;
        if (cur_task.hold_sink) hold_asks <= hold_asks + 1;
      end
      // Advance to the next word, or hold valid low
      if (drv_taken || !task_if.valid) begin
        if (pending.size() > 0 && idle_cycles >= pending[0].gap &&
            (!pending[0].after_drain || (!drv_taken && words_seen == words_due))) begin
          cur_task = pending.pop_front();
          task_if.valid         <= 1'b1;
          task_if.task_id       <= cur_task.rec.task_id;
          task_if.task_priority <= cur_task.rec.task_priority;
          task_if.run_time      <= cur_task.rec.run_time;
          task_if.batch_end     <= cur_task.batch_end;
          idle_cycles = 0;
        end else begin
          task_if.valid <= 1'b0;
          idle_cycles++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor: check each word, stall ready at random
  // ------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
      words_seen      <= 0;
      sink_wait     = 0;
      long_wait     = 0;
      hold_served   = 0;
      words_checked = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        check_result_word();
        words_seen <= words_seen + 1;
        words_checked++;
        // Take words back to back for a stretch, then stall at random
        sink_burst = (words_checked % 150) < 40;
        sink_wait  = sink_burst ? 0 : $urandom_range(0, 15);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      // Long hold-off once the flagged batch end was accepted
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        long_wait   = LONG_HOLD;
      end else if (long_wait > 0) begin
        long_wait--;
      end
      result_if.ready <= (sink_wait == 0) && (long_wait == 0);
    end
  end

  // ------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((task_if.valid && task_if.ready) || (result_if.valid && result_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("task_priority_sorter test failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sequence: build stimulus, reset, wait for drain, report
  // ------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    quiet_cycles   = 0;
    batch_dropped  = 1'b0;
    rst_n <= 1'b0;
    build_stimulus();
    total_tasks = pending.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (tasks_taken != total_tasks) @(posedge clk);
    while (words_seen != words_due) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("task_priority_sorter test passed");
    end else begin
      $display("task_priority_sorter test failed");
    end
    $finish;
  end

endmodule
